@@ sv/nsv_pkg.sv @@
`default_nettype none

package nsv_pkg;

	// Default width of the length counter
	localparam int LENGTH_BITS = 16;

	// Entries in the queue between the classifier and the checker
	localparam int QUEUE_DEPTH = 2;

	localparam int MODE_BITS = 3;
	localparam int BYTE_BITS = 8;

	// Check selected by the mode register
	typedef enum logic [MODE_BITS-1:0] {
		MODE_ASCII = 3'd0,
		MODE_DEC   = 3'd1,
		MODE_BIN   = 3'd2,
		MODE_HEX   = 3'd3,
		MODE_OCT   = 3'd4,
		MODE_FLOAT = 3'd5
	} mode_t;

	// Character codes
	localparam logic [BYTE_BITS-1:0] CH_NUL   = 8'h00;
	localparam logic [BYTE_BITS-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_BITS-1:0] CH_1     = 8'h31;
	localparam logic [BYTE_BITS-1:0] CH_7     = 8'h37;
	localparam logic [BYTE_BITS-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_BITS-1:0] CH_LA    = 8'h61;
	localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h66;
	localparam logic [BYTE_BITS-1:0] CH_UA    = 8'h41;
	localparam logic [BYTE_BITS-1:0] CH_UF    = 8'h46;
	localparam logic [BYTE_BITS-1:0] CH_DOT   = 8'h2e;
	localparam logic [BYTE_BITS-1:0] CH_COMMA = 8'h2c;
	localparam logic [BYTE_BITS-1:0] CH_MINUS = 8'h2d;
	localparam logic [BYTE_BITS-1:0] CH_PLUS  = 8'h2b;

	// One classified byte, handed from the classifier to the checker
	typedef struct packed {
		logic [MODE_BITS-1:0] mode;
		logic                 is_end;
		logic                 is_sign;
		logic                 is_dig;
		logic                 is_bin;
		logic                 is_oct;
		logic                 is_hex;
		logic                 is_mark;
		logic                 is_high;
	} nsv_item_t;

endpackage

`default_nettype wire

@@ sv/nsv_in_if.sv @@
`default_nettype none

interface nsv_in_if;
	logic                            valid;
	logic                            ready;
	logic [nsv_pkg::BYTE_BITS-1:0]   char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

`default_nettype wire

@@ sv/nsv_out_if.sv @@
`default_nettype none

interface nsv_out_if #(
	parameter int LENGTH_BITS = nsv_pkg::LENGTH_BITS
);
	logic                   valid;
	logic                   ready;
	logic                   is_valid;
	logic [LENGTH_BITS-1:0] string_length;

	modport source (output valid, output is_valid, output string_length, input ready);
	modport sink (input valid, input is_valid, input string_length, output ready);
endinterface

`default_nettype wire

@@ sv/nsv_front.sv @@
`default_nettype none

module nsv_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [nsv_pkg::MODE_BITS-1:0]   cfg_wdata,
	nsv_in_if.sink                               char_in,
	input  wire logic                            full,
	output nsv_pkg::nsv_item_t                   push_item,
	output logic                                 push
);

	logic [nsv_pkg::MODE_BITS-1:0] mode_q;
	logic [nsv_pkg::BYTE_BITS-1:0] c;

	// Hold the check mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nsv_pkg::MODE_DEC;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Accept while the queue has room
	assign char_in.ready = !full;
	assign push          = char_in.valid && !full;
	assign c             = char_in.char_byte;

	// Classify the byte and tag it with the mode in force
	always_comb begin
		push_item.mode    = mode_q;
		push_item.is_end  = (c == nsv_pkg::CH_NUL);
		push_item.is_sign = (c == nsv_pkg::CH_PLUS) || (c == nsv_pkg::CH_MINUS);
		push_item.is_dig  = (c >= nsv_pkg::CH_0) && (c <= nsv_pkg::CH_9);
		push_item.is_bin  = (c >= nsv_pkg::CH_0) && (c <= nsv_pkg::CH_1);
		push_item.is_oct  = (c >= nsv_pkg::CH_0) && (c <= nsv_pkg::CH_7);
		push_item.is_hex  = ((c >= nsv_pkg::CH_0) && (c <= nsv_pkg::CH_9))
			|| ((c >= nsv_pkg::CH_LA) && (c <= nsv_pkg::CH_LF))
			|| ((c >= nsv_pkg::CH_UA) && (c <= nsv_pkg::CH_UF));
		push_item.is_mark = (c == nsv_pkg::CH_DOT) || (c == nsv_pkg::CH_COMMA);
		push_item.is_high = c[nsv_pkg::BYTE_BITS-1];
	end

endmodule

`default_nettype wire

@@ sv/nsv_queue.sv @@
`default_nettype none

module nsv_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire nsv_pkg::nsv_item_t  push_item,
	input  wire logic                pop,
	output nsv_pkg::nsv_item_t       head_item,
	output logic                     empty,
	output logic                     full
);

	localparam int DEPTH = nsv_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	nsv_pkg::nsv_item_t  entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_BITS'(DEPTH));
	assign head_item = entry_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

@@ sv/nsv_back.sv @@
`default_nettype none

module nsv_back #(
	parameter int LENGTH_BITS = nsv_pkg::LENGTH_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire nsv_pkg::nsv_item_t  head_item,
	input  wire logic                empty,
	output logic                     pop,
	nsv_out_if.source                result_out
);

	logic                   at_start_q;
	logic                   has_body_q;
	logic                   decimal_seen_q;
	logic                   last_was_decimal_q;
	logic                   failed_q;
	logic [LENGTH_BITS-1:0] len_q;

	logic                   out_valid_q;
	logic                   out_ok_q;
	logic [LENGTH_BITS-1:0] out_len_q;

	logic                   body_d;
	logic                   dec_d;
	logic                   last_d;
	logic                   fail_d;
	logic                   verdict;
	logic                   out_free;

	// Take the head item unless a terminator meets a full output register
	assign out_free = !out_valid_q || result_out.ready;
	assign pop      = !empty && (!head_item.is_end || out_free);

	// Update the string flags for one byte
	always_comb begin
		body_d = has_body_q;
		dec_d  = decimal_seen_q;
		last_d = last_was_decimal_q;
		fail_d = failed_q;
		unique case (head_item.mode)
			nsv_pkg::MODE_ASCII: begin
				if (head_item.is_high) fail_d = 1'b1;
			end
			nsv_pkg::MODE_DEC: begin
				if (at_start_q && head_item.is_sign) begin
					fail_d = failed_q;
				end else if (head_item.is_dig) begin
					body_d = 1'b1;
				end else begin
					fail_d = 1'b1;
				end
			end
			nsv_pkg::MODE_BIN: begin
				if (head_item.is_bin) body_d = 1'b1;
				else fail_d = 1'b1;
			end
			nsv_pkg::MODE_HEX: begin
				if (head_item.is_hex) body_d = 1'b1;
				else fail_d = 1'b1;
			end
			nsv_pkg::MODE_OCT: begin
				if (head_item.is_oct) body_d = 1'b1;
				else fail_d = 1'b1;
			end
			nsv_pkg::MODE_FLOAT: begin
				if (at_start_q && head_item.is_sign) begin
					fail_d = failed_q;
				end else if (head_item.is_dig) begin
					body_d = 1'b1;
					last_d = 1'b0;
				end else if (head_item.is_mark && !decimal_seen_q && has_body_q) begin
					dec_d  = 1'b1;
					last_d = 1'b1;
				end else begin
					fail_d = 1'b1;
				end
			end
			default: fail_d = 1'b1;
		endcase
	end

	// Judge the finished string under the mode of the terminator
	always_comb begin
		unique case (head_item.mode) inside
			nsv_pkg::MODE_ASCII: verdict = 1'b1;
			nsv_pkg::MODE_DEC,
			nsv_pkg::MODE_BIN,
			nsv_pkg::MODE_HEX,
			nsv_pkg::MODE_OCT:   verdict = has_body_q;
			nsv_pkg::MODE_FLOAT: verdict = has_body_q && !last_was_decimal_q;
			default:             verdict = 1'b0;
		endcase
	end

	// Advance the string state; clear it at the terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q         <= 1'b1;
			has_body_q         <= 1'b0;
			decimal_seen_q     <= 1'b0;
			last_was_decimal_q <= 1'b0;
			failed_q           <= 1'b0;
			len_q              <= '0;
		end else if (pop) begin
			if (head_item.is_end) begin
				at_start_q         <= 1'b1;
				has_body_q         <= 1'b0;
				decimal_seen_q     <= 1'b0;
				last_was_decimal_q <= 1'b0;
				failed_q           <= 1'b0;
				len_q              <= '0;
			end else begin
				at_start_q         <= 1'b0;
				has_body_q         <= body_d;
				decimal_seen_q     <= dec_d;
				last_was_decimal_q <= last_d;
				failed_q           <= fail_d;
				if (len_q != '1) len_q <= len_q + 1'b1;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head_item.is_end) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.is_end) begin
			out_ok_q  <= !failed_q && verdict;
			out_len_q <= len_q;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.is_valid      = out_ok_q;
	assign result_out.string_length = out_len_q;

`ifndef NO_ASSERTIONS
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.is_end) |=> (at_start_q && (len_q == '0) && !failed_q))
		else $error("string state not cleared after terminator");
	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(failed_q && !(pop && head_item.is_end)) |=> failed_q)
		else $error("failure flag dropped mid-string");
	a_mark_needs_body: assert property (@(posedge clk) disable iff (!arst_n)
		decimal_seen_q |-> has_body_q)
		else $error("decimal mark recorded without a leading digit");
	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop && head_item.is_end))
		else $error("result raised without a terminator");
`endif

endmodule

`default_nettype wire

@@ sv/ascii_number_string_validator_unit.sv @@
// Channel     Dir  Payload                          Handshake
// char_in     in   char_byte[7:0]                   valid/ready
// result_out  out  is_valid, string_length[L-1:0]   valid/ready
// cfg         in   cfg_wdata[2:0] (check mode)      cfg_we, no wait
//
// One byte is accepted per cycle; a classifier feeds a two-entry queue and
// the checker retires one queued byte per cycle.
// A result is registered as its zero byte leaves the queue and sits in
// an output register until taken; further bytes of the next string flow on.
// A stalled result holds back only the next terminator; the queue then fills
// and char_in.ready drops. Reset clears all string state, mode becomes 1.
`default_nettype none

module ascii_number_string_validator_unit #(
	parameter int LENGTH_BITS = nsv_pkg::LENGTH_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [nsv_pkg::MODE_BITS-1:0]   cfg_wdata,
	nsv_in_if.sink                               char_in,
	nsv_out_if.source                            result_out
);

	nsv_pkg::nsv_item_t push_item;
	nsv_pkg::nsv_item_t head_item;
	logic               push;
	logic               pop;
	logic               empty;
	logic               full;

	nsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.char_in   (char_in),
		.full      (full),
		.push_item (push_item),
		.push      (push)
	);

	nsv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.empty     (empty),
		.full      (full)
	);

	nsv_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_item  (head_item),
		.empty      (empty),
		.pop        (pop),
		.result_out (result_out)
	);

endmodule

`default_nettype wire

@@ tb/sv/ascii_number_string_validator_unit_tb.sv @@
`timescale 1ns / 1ps

module ascii_number_string_validator_unit_tb;
	import nsv_pkg::*;

	localparam int LB = LENGTH_BITS;
	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_BYTES = 500;
	localparam int NO_SPLIT = -1;
	localparam int MAX_REPORTS = 10;
	localparam int DIR_ROWS = 26;
	localparam logic [MODE_BITS-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_BITS-1:0] MODE_SPARE7 = 3'd7;

	typedef logic [BYTE_BITS-1:0] char_q_t [$];

	typedef struct {
		bit                is_valid;
		logic [LB-1:0]     string_length;
	} verdict_t;

	typedef struct {
		bit                typed;
		bit                is_valid;
		logic [LB-1:0]     string_length;
	} dir_answer_t;

	typedef struct {
		logic [MODE_BITS-1:0] mode;
		string                text;
		int                   split;
		logic [MODE_BITS-1:0] mode2;
		bit                   typed;
		bit                   is_valid;
		int                   string_length;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MODE_BITS-1:0] cfg_wdata;

	nsv_in_if char_ch ();
	nsv_out_if #(.LENGTH_BITS(LB)) result_ch ();

	ascii_number_string_validator_unit #(.LENGTH_BITS(LB)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.char_in    (char_ch.sink),
		.result_out (result_ch.source)
	);

	// Directed strings: mode, text, byte index of a mid-string mode switch,
	// mode after the switch, and a hand-typed result where it is obvious
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{MODE_DEC,    "123",       NO_SPLIT, MODE_DEC,   1'b1, 1'b1, 3},
		'{MODE_DEC,    "",          NO_SPLIT, MODE_DEC,   1'b1, 1'b0, 0},
		'{MODE_DEC,    "-0",        NO_SPLIT, MODE_DEC,   1'b0, 1'b0, 0},
		'{MODE_DEC,    "+",         NO_SPLIT, MODE_DEC,   1'b1, 1'b0, 1},
		'{MODE_DEC,    "+-5",       NO_SPLIT, MODE_DEC,   1'b0, 1'b0, 0},
		'{MODE_DEC,    "9\377",     NO_SPLIT, MODE_DEC,   1'b1, 1'b0, 2},
		'{MODE_ASCII,  "",          NO_SPLIT, MODE_ASCII, 1'b1, 1'b1, 0},
		'{MODE_ASCII,  "+ ~\177",   NO_SPLIT, MODE_ASCII, 1'b0, 1'b0, 0},
		'{MODE_ASCII,  "ab\200",    NO_SPLIT, MODE_ASCII, 1'b1, 1'b0, 3},
		'{MODE_BIN,    "0101",      NO_SPLIT, MODE_BIN,   1'b1, 1'b1, 4},
		'{MODE_BIN,    "-1",        NO_SPLIT, MODE_BIN,   1'b0, 1'b0, 0},
		'{MODE_BIN,    "012",       NO_SPLIT, MODE_BIN,   1'b0, 1'b0, 0},
		'{MODE_HEX,    "09afAF",    NO_SPLIT, MODE_HEX,   1'b1, 1'b1, 6},
		'{MODE_HEX,    "@`gG/:",    NO_SPLIT, MODE_HEX,   1'b0, 1'b0, 0},
		'{MODE_OCT,    "01234567",  NO_SPLIT, MODE_OCT,   1'b1, 1'b1, 8},
		'{MODE_OCT,    "8",         NO_SPLIT, MODE_OCT,   1'b0, 1'b0, 0},
		'{MODE_FLOAT,  "-3.14",     NO_SPLIT, MODE_FLOAT, 1'b0, 1'b0, 0},
		'{MODE_FLOAT,  "+1,5",      NO_SPLIT, MODE_FLOAT, 1'b0, 1'b0, 0},
		'{MODE_FLOAT,  ".5",        NO_SPLIT, MODE_FLOAT, 1'b0, 1'b0, 0},
		'{MODE_FLOAT,  "5.",        NO_SPLIT, MODE_FLOAT, 1'b0, 1'b0, 0},
		'{MODE_FLOAT,  "1.2,3",     NO_SPLIT, MODE_FLOAT, 1'b0, 1'b0, 0},
		'{MODE_FLOAT,  "",          NO_SPLIT, MODE_FLOAT, 1'b1, 1'b0, 0},
		'{MODE_SPARE6, "1",         NO_SPLIT, MODE_SPARE6, 1'b1, 1'b0, 1},
		'{MODE_SPARE7, "",          NO_SPLIT, MODE_SPARE7, 1'b1, 1'b0, 0},
		'{MODE_DEC,    "12.5",      2,        MODE_FLOAT, 1'b0, 1'b0, 0},
		'{MODE_FLOAT,  "1.",        2,        MODE_DEC,   1'b0, 1'b0, 0}
	};

	// Scanner state mirrored from the block
	logic [MODE_BITS-1:0] scan_mode;
	bit at_start;
	bit sign_taken;
	bit has_body;
	bit mark_seen;
	bit mark_last;
	bit failed;
	logic [LB-1:0] length_count;

	verdict_t pending_results [$];
	dir_answer_t dir_answers [$];

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_requests;
	int hold_grants;
	int hold_left;
	int quiet_cycles;
	int mismatch_count;
	int bytes_sent;
	int results_checked;
	int valid_results;
	int mode_writes;

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	function automatic bit in_span(input logic [BYTE_BITS-1:0] c,
		input logic [BYTE_BITS-1:0] lo, input logic [BYTE_BITS-1:0] hi);
		return c >= lo && c <= hi;
	endfunction

	function automatic bit is_sign(input logic [BYTE_BITS-1:0] c);
		return c == CH_PLUS || c == CH_MINUS;
	endfunction

	function automatic void clear_scan();
		at_start = 1'b1;
		sign_taken = 1'b0;
		has_body = 1'b0;
		mark_seen = 1'b0;
		mark_last = 1'b0;
		failed = 1'b0;
		length_count = '0;
	endfunction

	// Advance the scanner by one nonzero byte under the current mode
	function automatic void scan_byte(input logic [BYTE_BITS-1:0] c);
		bit first;
		first = at_start;
		at_start = 1'b0;
		if (length_count != '1)
			length_count = length_count + 1'b1;
		case (scan_mode)
			MODE_ASCII: begin
				if (c[BYTE_BITS-1])
					failed = 1'b1;
			end
			MODE_DEC: begin
				if (first && is_sign(c))
					sign_taken = 1'b1;
				else if (in_span(c, CH_0, CH_9))
					has_body = 1'b1;
				else
					failed = 1'b1;
			end
			MODE_BIN: begin
				if (in_span(c, CH_0, CH_1))
					has_body = 1'b1;
				else
					failed = 1'b1;
			end
			MODE_HEX: begin
				if (in_span(c, CH_0, CH_9) || in_span(c, CH_LA, CH_LF) || in_span(c, CH_UA, CH_UF))
					has_body = 1'b1;
				else
					failed = 1'b1;
			end
			MODE_OCT: begin
				if (in_span(c, CH_0, CH_7))
					has_body = 1'b1;
				else
					failed = 1'b1;
			end
			MODE_FLOAT: begin
				if (first && is_sign(c)) begin
					sign_taken = 1'b1;
				end else if (in_span(c, CH_0, CH_9)) begin
					has_body = 1'b1;
					mark_last = 1'b0;
				end else if ((c == CH_DOT || c == CH_COMMA) && !mark_seen && has_body) begin
					mark_seen = 1'b1;
					mark_last = 1'b1;
				end else begin
					failed = 1'b1;
				end
			end
			default: failed = 1'b1;
		endcase
	endfunction

	// Decide the finished string under the mode in force at the terminator
	function automatic bit scan_verdict();
		if (failed)
			return 1'b0;
		case (scan_mode)
			MODE_ASCII: return 1'b1;
			MODE_DEC, MODE_BIN, MODE_HEX, MODE_OCT: return has_body;
			MODE_FLOAT: return has_body && !mark_last;
			default: return 1'b0;
		endcase
	endfunction

	// Build one string, mostly well formed for the mode, a quarter damaged
	function automatic char_q_t make_string(input logic [MODE_BITS-1:0] mode);
		char_q_t s;
		logic [BYTE_BITS-1:0] c;
		int n;
		int pick;
		int pos;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			case (mode)
				MODE_ASCII: c = BYTE_BITS'($urandom_range(1, 127));
				MODE_BIN: c = CH_0 + BYTE_BITS'($urandom_range(0, 1));
				MODE_OCT: c = CH_0 + BYTE_BITS'($urandom_range(0, 7));
				MODE_HEX: begin
					pick = $urandom_range(0, 21);
					if (pick < 10)
						c = CH_0 + BYTE_BITS'(pick);
					else if (pick < 16)
						c = CH_LA + BYTE_BITS'(pick - 10);
					else
						c = CH_UA + BYTE_BITS'(pick - 16);
				end
				MODE_DEC, MODE_FLOAT: c = CH_0 + BYTE_BITS'($urandom_range(0, 9));
				default: c = BYTE_BITS'($urandom_range(1, 255));
			endcase
			s.push_back(c);
		end
		if (mode == MODE_FLOAT && n >= 3 && $urandom_range(0, 1) == 1)
			s[$urandom_range(1, n - 2)] = ($urandom_range(0, 1) == 1) ? CH_DOT : CH_COMMA;
		if ((mode == MODE_DEC || mode == MODE_FLOAT) && $urandom_range(0, 2) == 0)
			s.push_front(($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS);

		// Damage: empty, near-miss byte, any byte, or a trailing mark
		if ($urandom_range(0, 3) == 0) begin
			pos = $urandom_range(0, s.size() - 1);
			case ($urandom_range(0, 3))
				0: s.delete();
				1: begin
					case ($urandom_range(0, 9))
						0: s[pos] = CH_PLUS;
						1: s[pos] = CH_MINUS;
						2: s[pos] = CH_DOT;
						3: s[pos] = CH_0 - 1'b1;
						4: s[pos] = CH_9 + 1'b1;
						5: s[pos] = CH_1 + 1'b1;
						6: s[pos] = CH_7 + 1'b1;
						7: s[pos] = CH_LF + 1'b1;
						8: s[pos] = CH_UF + 1'b1;
						default: s[pos] = CH_UA - 1'b1;
					endcase
				end
				2: s[pos] = BYTE_BITS'($urandom_range(1, 255));
				default: s.push_back(($urandom_range(0, 1) == 1) ? CH_DOT : CH_COMMA);
			endcase
		end
		return s;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// Offer one item from a falling edge, return at the edge that takes it
	task automatic send_byte(input logic [BYTE_BITS-1:0] c);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(negedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_byte <= c;
		do @(posedge clk); while (!char_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_text(input char_q_t s);
		foreach (s[i])
			send_byte(s[i]);
		send_byte(CH_NUL);
	endtask

	// Drop valid, drain all results, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		char_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic [MODE_BITS-1:0] mode);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_writes++;
	endtask

	// Random strings in segments, each under a fresh mode
	task automatic run_phase(input int tx_pct, input int rx_pct, input bit with_hold);
		int start_bytes;
		bit held;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start_bytes = bytes_sent;
		held = 1'b0;
		while (bytes_sent - start_bytes < PHASE_BYTES) begin
			settle();
			write_mode(MODE_BITS'($urandom_range(0, 7)));
			if (with_hold && !held) begin
				hold_requests++;
				held = 1'b1;
			end
			repeat ($urandom_range(8, 20))
				send_text(make_string(($urandom_range(0, 5) == 0) ?
					MODE_BITS'($urandom_range(0, 7)) : scan_mode));
		end
	endtask

	// Track mode writes
	always @(posedge clk) begin
		if (arst_n && cfg_we)
			scan_mode = cfg_wdata;
	end

	// Predict on every accepted byte; a zero byte yields one result
	always @(posedge clk) begin : predict_input
		verdict_t want;
		dir_answer_t answer;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (char_ch.char_byte == CH_NUL) begin
				want.is_valid = scan_verdict();
				want.string_length = length_count;
				if (dir_answers.size() != 0) begin
					answer = dir_answers.pop_front();
					if (answer.typed) begin
						want.is_valid = answer.is_valid;
						want.string_length = answer.string_length;
					end
				end
				pending_results.push_back(want);
				clear_scan();
			end else begin
				scan_byte(char_ch.char_byte);
			end
		end
	end

	// Compare each taken result with the oldest prediction
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_checked++;
			if (result_ch.is_valid)
				valid_results++;
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("result with nothing pending: is_valid %0b length %0d",
					result_ch.is_valid, result_ch.string_length));
			end else begin
				want = pending_results.pop_front();
				if (result_ch.is_valid !== want.is_valid)
					note_mismatch($sformatf("is_valid expected %0b got %0b",
						want.is_valid, result_ch.is_valid));
				if (result_ch.string_length !== want.string_length)
					note_mismatch($sformatf("string_length expected %0d got %0d",
						want.string_length, result_ch.string_length));
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_grants != hold_requests) begin
				hold_grants++;
				hold_left = HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (char_ch.valid && char_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, pending_results.size());
			$display("ascii_number_string_validator_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		dir_answer_t answer;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		char_ch.valid = 1'b0;
		char_ch.char_byte = '0;
		scan_mode = MODE_DEC;
		clear_scan();
		tx_idle_pct = 23;
		rx_idle_pct = 55;
		hold_requests = 0;
		hold_grants = 0;
		hold_left = 0;
		quiet_cycles = 0;
		mismatch_count = 0;
		bytes_sent = 0;
		results_checked = 0;
		valid_results = 0;
		mode_writes = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed rows; the first one runs on the reset mode
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != scan_mode) begin
				settle();
				write_mode(dir_rows[i].mode);
			end
			answer.typed = dir_rows[i].typed;
			answer.is_valid = dir_rows[i].is_valid;
			answer.string_length = LB'(dir_rows[i].string_length);
			dir_answers.push_back(answer);
			for (int k = 0; k < dir_rows[i].text.len(); k++) begin
				if (k == dir_rows[i].split) begin
					settle();
					write_mode(dir_rows[i].mode2);
				end
				send_byte(dir_rows[i].text[k]);
			end
			// Switch right before the terminator when the split sits at the end
			if (dir_rows[i].split == dir_rows[i].text.len()) begin
				settle();
				write_mode(dir_rows[i].mode2);
			end
			send_byte(CH_NUL);
		end

		run_phase(23, 55, 1'b0);
		run_phase(55, 23, 1'b0);
		run_phase(0, 0, 1'b1);

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d bytes, %0d results checked (%0d valid), %0d mode writes over all",
			bytes_sent, results_checked, valid_results, mode_writes);
		$display("eight mode codes, mode switches inside strings and a %0d-cycle receiver hold-off",
			HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("ascii_number_string_validator_unit regression: pass");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("ascii_number_string_validator_unit regression: fail");
		end
		$finish;
	end

endmodule

@@ ascii_number_string_validator_unit.f @@
sv/nsv_pkg.sv
sv/nsv_in_if.sv
sv/nsv_out_if.sv
sv/nsv_front.sv
sv/nsv_queue.sv
sv/nsv_back.sv
sv/ascii_number_string_validator_unit.sv
tb/sv/ascii_number_string_validator_unit_tb.sv
